// File: rtl/pid_angle_controller_top_assert.svh
// Assertion macros used by the RTL controller (pac_ctrl).
`ifndef PID_ANGLE_CONTROLLER_TOP_ASSERT_SVH
`define PID_ANGLE_CONTROLLER_TOP_ASSERT_SVH

// Check that holds at every clock edge outside reset.
`define PAC_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Check on the cycle after a trigger.
`define PAC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/pac_pkg.sv
package pac_pkg;

  localparam int ENCODER_BITS_DEF = 10;
  localparam int DSR_W            = 17;
  localparam int RATE_W           = 19;
  localparam int CFG_ADDR_W       = 3;
  localparam int CFG_DATA_W       = 18;
  localparam int OUT_W            = 48;

  localparam logic [DSR_W-1:0] MEAS_SCALE = 17'd92160;
  localparam logic [DSR_W-1:0] DUTY_DIV   = 17'd92160;
  localparam logic [7:0]       DUTY_SCALE = 8'd255;

  // 255/92160 = 17/(3*2^11); the divide by 3 is a reciprocal multiply
  localparam logic [4:0]  DUTY_NUM    = 5'd17;
  localparam int          DUTY_SHIFT  = 11;
  localparam logic [15:0] THIRD_RECIP = 16'd43691;
  localparam int          THIRD_SHIFT = 17;

  localparam logic [CFG_ADDR_W-1:0] REG_SETPOINT    = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_GAIN_PROP   = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_GAIN_INTEG  = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_GAIN_DERIV  = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_DRIVE_UPPER = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_DRIVE_LOWER = 3'd5;

  localparam logic signed [17:0] DRIVE_UPPER_RST = 18'sd92160;
  localparam logic signed [17:0] DRIVE_LOWER_RST = 18'sd0;

  typedef struct packed {
    logic ld_in;
    logic est_meas;
    logic ld_meas;
    logic ld_err;
    logic ld_prod;
    logic ld_integ;
    logic div_rate;
    logic ld_rate;
    logic ld_pi_lo;
    logic acc_lo;
    logic acc_hi;
    logic acc_d;
    logic ld_drive;
    logic ld_duty;
    logic out_load;
  } pac_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic div_done;
    logic out_busy;
  } pac_stat_t;

endpackage

// File: rtl/pac_div.sv
module pac_div import pac_pkg::*; #(
  parameter int DVD_W = RATE_W,
  parameter int DIV_W = DSR_W
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DIV_W-1:0] divisor,
  output logic [DVD_W-1:0] quotient,
  output logic             busy,
  output logic             done
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] quo;
  logic [DIV_W-1:0] rem;
  logic [DIV_W-1:0] dsr;
  logic [CNT_W-1:0] cnt;
  logic [DIV_W:0]   trial;
  logic             fits;

  assign trial    = {rem, quo[DVD_W-1]};
  assign fits     = trial >= {1'b0, dsr};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DVD_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (busy) begin
      quo <= {quo[DVD_W-2:0], fits};
      rem <= fits ? DIV_W'(trial - {1'b0, dsr}) : trial[DIV_W-1:0];
    end
  end

endmodule

// File: rtl/pac_ctrl.sv
`include "pid_angle_controller_top_assert.svh"

module pac_ctrl import pac_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  pac_stat_t stat,
  output pac_cmd_t  cmd
);

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_MEAS_EST  = 4'd1;
  localparam logic [3:0] S_MEAS_FIX  = 4'd2;
  localparam logic [3:0] S_ERR       = 4'd3;
  localparam logic [3:0] S_PROD      = 4'd4;
  localparam logic [3:0] S_INTEG     = 4'd5;
  localparam logic [3:0] S_RATE_WAIT = 4'd6;
  localparam logic [3:0] S_PI_LO     = 4'd7;
  localparam logic [3:0] S_ACC_LO    = 4'd8;
  localparam logic [3:0] S_ACC_HI    = 4'd9;
  localparam logic [3:0] S_ACC_D     = 4'd10;
  localparam logic [3:0] S_CLAMP     = 4'd11;
  localparam logic [3:0] S_DUTY      = 4'd12;
  localparam logic [3:0] S_OUT       = 4'd13;

  logic [3:0] state;
  logic [3:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    in_ready   = 1'b0;
    state_next = state;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.ld_in  = 1'b1;
          state_next = S_MEAS_EST;
        end
      end
      S_MEAS_EST: begin
        cmd.est_meas = 1'b1;
        state_next   = S_MEAS_FIX;
      end
      S_MEAS_FIX: begin
        cmd.ld_meas = 1'b1;
        state_next  = S_ERR;
      end
      S_ERR: begin
        cmd.ld_err = 1'b1;
        state_next = S_PROD;
      end
      S_PROD: begin
        cmd.ld_prod = 1'b1;
        state_next  = S_INTEG;
      end
      S_INTEG: begin
        cmd.ld_integ = 1'b1;
        cmd.div_rate = 1'b1;
        state_next   = S_RATE_WAIT;
      end
      S_RATE_WAIT: begin
        if (stat.div_done) begin
          cmd.ld_rate = 1'b1;
          state_next  = S_PI_LO;
        end
      end
      S_PI_LO: begin
        cmd.ld_pi_lo = 1'b1;
        state_next   = S_ACC_LO;
      end
      S_ACC_LO: begin
        cmd.acc_lo = 1'b1;
        state_next = S_ACC_HI;
      end
      S_ACC_HI: begin
        cmd.acc_hi = 1'b1;
        state_next = S_ACC_D;
      end
      S_ACC_D: begin
        cmd.acc_d  = 1'b1;
        state_next = S_CLAMP;
      end
      S_CLAMP: begin
        cmd.ld_drive = 1'b1;
        state_next   = S_DUTY;
      end
      S_DUTY: begin
        cmd.ld_duty = 1'b1;
        state_next  = S_OUT;
      end
      S_OUT: begin
        if (!stat.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  `PAC_ASSERT_ALWAYS(a_div_start_free, !(cmd.div_rate && stat.div_busy), "divider started while busy")
  `PAC_ASSERT_ALWAYS(a_done_in_wait, !stat.div_done || state == S_RATE_WAIT, "quotient arrived outside the wait state")
  `PAC_ASSERT_ALWAYS(a_out_load_free, !cmd.out_load || !stat.out_busy, "result overwritten before taken")
  `PAC_ASSERT_NEXT(a_one_request, in_valid && in_ready, !in_ready, "second request taken during work")

endmodule

// File: rtl/pac_dp.sv
module pac_dp import pac_pkg::*; #(
  parameter int ENCODER_BITS = ENCODER_BITS_DEF,
  localparam int IN_W = ((ENCODER_BITS + 16 + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [IN_W-1:0]       in_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  pac_cmd_t              cmd,
  output pac_stat_t             stat,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [OUT_W-1:0]      out_data
);

  localparam int T_W = ENCODER_BITS + 18;
  localparam logic [DSR_W-1:0] FULL = DSR_W'((1 << ENCODER_BITS) - 1);

  logic [16:0]        setpoint;
  logic [15:0]        gain_p;
  logic [15:0]        gain_i;
  logic [15:0]        gain_d;
  logic signed [17:0] drive_upper;
  logic signed [17:0] drive_lower;

  logic [ENCODER_BITS-1:0] count_r;
  logic [15:0]             elapsed_r;
  logic [T_W-1:0]          meas_t_r;
  logic [16:0]             est_r;
  logic [16:0]             measured_r;
  logic signed [17:0]      error_r;
  logic signed [17:0]      prev_err;
  logic signed [33:0]      ie_r;
  logic signed [18:0]      diff_r;
  logic signed [18:0]      rate_r;
  logic signed [47:0]      integ;
  logic signed [41:0]      pp;
  logic signed [63:0]      acc;
  logic signed [17:0]      drive_r;
  logic [7:0]              duty_r;

  logic               div_start;
  logic [RATE_W-1:0]  div_dvd;
  logic [DSR_W-1:0]   div_dsr;
  logic [RATE_W-1:0]  quot;
  logic               div_busy;
  logic               div_done;

  logic [T_W-1:0]     meas_t;
  logic [T_W-1:0]     fold_sum;
  logic [16:0]        meas_est;
  logic [T_W-1:0]     meas_rem;
  logic [16:0]        meas_fix;
  logic signed [17:0] error_next;
  logic signed [34:0] ie_full;
  logic signed [34:0] prop_p;
  logic signed [48:0] integ_sum;
  logic signed [47:0] integ_next;
  logic [18:0]        diff_mag;
  logic [18:0]        rate_q;
  logic signed [18:0] rate_next;
  logic signed [41:0] pil;
  logic signed [40:0] pih;
  logic signed [35:0] pdp;
  logic signed [55:0] shifted;
  logic signed [55:0] up56;
  logic signed [55:0] lo56;
  logic signed [55:0] t_up;
  logic signed [55:0] t_lo;
  logic [21:0]        duty_x;
  logic [26:0]        duty_p;
  logic [9:0]         duty_q;
  logic [7:0]         duty_next;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      setpoint    <= '0;
      gain_p      <= '0;
      gain_i      <= '0;
      gain_d      <= '0;
      drive_upper <= DRIVE_UPPER_RST;
      drive_lower <= DRIVE_LOWER_RST;
    end else if (cfg_valid) begin
      case (cfg_addr)
        REG_SETPOINT:    setpoint    <= cfg_data[16:0];
        REG_GAIN_PROP:   gain_p      <= cfg_data[15:0];
        REG_GAIN_INTEG:  gain_i      <= cfg_data[15:0];
        REG_GAIN_DERIV:  gain_d      <= cfg_data[15:0];
        REG_DRIVE_UPPER: drive_upper <= $signed(cfg_data);
        REG_DRIVE_LOWER: drive_lower <= $signed(cfg_data);
        default: begin
        end
      endcase
    end
  end

  // divide by 2^N-1: fold the high digits down, then one compare and subtract
  assign meas_t   = T_W'(count_r) * T_W'(MEAS_SCALE);
  assign fold_sum = meas_t + (meas_t >> ENCODER_BITS) + (meas_t >> (2 * ENCODER_BITS))
                  + (meas_t >> (3 * ENCODER_BITS));
  assign meas_est = fold_sum[ENCODER_BITS +: 17];
  assign meas_rem = meas_t_r - (T_W'(est_r) << ENCODER_BITS) + T_W'(est_r);
  assign meas_fix = (meas_rem >= T_W'(FULL)) ? est_r + 17'd1 : est_r;

  assign error_next = $signed({1'b0, setpoint}) - $signed({1'b0, measured_r});
  assign ie_full    = error_r * $signed({1'b0, elapsed_r});
  assign prop_p     = $signed({1'b0, gain_p}) * error_r;
  assign integ_sum  = {integ[47], integ} + {{15{ie_r[33]}}, ie_r};

  always_comb begin
    if (integ_sum[48] != integ_sum[47]) begin
      integ_next = integ_sum[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
    end else begin
      integ_next = integ_sum[47:0];
    end
  end

  assign diff_mag  = diff_r[18] ? 19'(-diff_r) : 19'(diff_r);
  assign rate_q    = {1'b0, quot[17:0]};
  assign rate_next = (elapsed_r == 16'd0) ? 19'sd0
                   : (diff_r[18] ? -$signed(rate_q) : $signed(rate_q));

  assign pil = $signed({1'b0, gain_i}) * $signed({1'b0, integ[23:0]});
  assign pih = $signed({1'b0, gain_i}) * $signed(integ[47:24]);
  assign pdp = $signed({1'b0, gain_d}) * rate_r;

  assign shifted = $signed(acc[63:8]);
  assign up56    = $signed({{38{drive_upper[17]}}, drive_upper});
  assign lo56    = $signed({{38{drive_lower[17]}}, drive_lower});
  assign t_up    = (shifted > up56) ? up56 : shifted;
  assign t_lo    = (t_up < lo56) ? lo56 : t_up;

  assign duty_x    = 22'(drive_r[16:0]) * 22'(DUTY_NUM);
  assign duty_p    = 27'(duty_x[21:DUTY_SHIFT]) * 27'(THIRD_RECIP);
  assign duty_q    = duty_p[26:THIRD_SHIFT];
  assign duty_next = drive_r[17] ? 8'd0 : ((|duty_q[9:8]) ? 8'hFF : duty_q[7:0]);

  assign div_start = cmd.div_rate;
  assign div_dvd   = diff_mag;
  assign div_dsr   = {1'b0, elapsed_r};

  pac_div #(
    .DVD_W (RATE_W),
    .DIV_W (DSR_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dsr),
    .quotient (quot),
    .busy     (div_busy),
    .done     (div_done)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      integ    <= '0;
      prev_err <= '0;
    end else if (cmd.ld_integ) begin
      integ    <= integ_next;
      prev_err <= error_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_in) begin
      count_r   <= in_data[ENCODER_BITS-1:0];
      elapsed_r <= in_data[ENCODER_BITS +: 16];
    end
    if (cmd.est_meas) begin
      meas_t_r <= meas_t;
      est_r    <= meas_est;
    end
    if (cmd.ld_meas) begin
      measured_r <= meas_fix;
    end
    if (cmd.ld_err) begin
      error_r <= error_next;
    end
    if (cmd.ld_prod) begin
      ie_r   <= ie_full[33:0];
      diff_r <= {error_r[17], error_r} - {prev_err[17], prev_err};
    end
    if (cmd.ld_rate) begin
      rate_r <= rate_next;
    end
    if (cmd.ld_prod) begin
      acc <= {{29{prop_p[34]}}, prop_p};
    end else if (cmd.acc_lo || cmd.acc_d) begin
      acc <= acc + {{22{pp[41]}}, pp};
    end else if (cmd.acc_hi) begin
      acc <= acc + {pp[39:0], 24'd0};
    end
    if (cmd.ld_pi_lo) begin
      pp <= pil;
    end else if (cmd.acc_lo) begin
      pp <= {pih[40], pih};
    end else if (cmd.acc_hi) begin
      pp <= {{6{pdp[35]}}, pdp};
    end
    if (cmd.ld_drive) begin
      drive_r <= t_lo[17:0];
    end
    if (cmd.ld_duty) begin
      duty_r <= duty_next;
    end
    if (cmd.out_load) begin
      out_data <= {5'd0, measured_r, duty_r, drive_r};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign stat.div_busy = div_busy;
  assign stat.div_done = div_done;
  assign stat.out_busy = out_valid & ~out_ready;

endmodule

// File: rtl/pid_angle_controller_top.sv
// The time from request to result valid does not depend on ENCODER_BITS.
// One request is worked at a time; its result is loaded only once the last one is taken.
// The radix-2 rate divider yields one quotient bit a cycle; other steps are single states.
// A finished result waits in the output register while the next request is taken.
// Reset (rst, synchronous, active high) clears integral, last error, output valid,
// and returns gains and setpoint to zero, upper clamp to 360 deg, lower clamp to 0.
module pid_angle_controller_top import pac_pkg::*; #(
  parameter int ENCODER_BITS = ENCODER_BITS_DEF,
  localparam int IN_W = ((ENCODER_BITS + 16 + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_W-1:0]       s_axis_tdata,  // encoder_count, elapsed_ms, zero pad
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_W-1:0]      m_axis_tdata,  // drive_angle, pwm_duty, measured_angle, pad
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  pac_cmd_t  cmd;
  pac_stat_t stat;

  pac_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  pac_dp #(
    .ENCODER_BITS (ENCODER_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (s_axis_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata)
  );

endmodule
